@@ hw/rtl/biou_pkg.sv @@
package biou_pkg;

   localparam int NumLabels   = 4096;
   localparam int LabelIdxW   = 12;
   localparam int CoordW      = 12;
   localparam int LabelW      = 13;
   localparam int IouFracBits = 14;
   localparam int IouW        = 16;
   localparam int NumClW      = 13;
   localparam int HwW         = 8;
   localparam int CorrW       = 16;
   // signed coordinate span for truth box edges
   localparam int SCoordW     = CoordW + 2;
   // box areas up to 4096*4096 and truth area up to 511*511
   localparam int AreaW       = 2 * CoordW + 1;
   localparam int UnionW      = AreaW + 2;
   localparam int DivW        = AreaW + IouFracBits;
   localparam int DivCntW     = 6;

   localparam logic [1:0] OpPixel = 2'd0;
   localparam logic [1:0] OpQuery = 2'd1;
   localparam logic [1:0] OpClear = 2'd2;

   localparam logic [1:0] CsrNumClusters = 2'd0;
   localparam logic [1:0] CsrHalfWidth   = 2'd1;
   localparam logic [1:0] CsrAreaCorr    = 2'd2;

   localparam logic [IouW-1:0] IouMax = '1;

   // controller to datapath commands
   typedef struct packed {
      logic       pix_rd;     // read table entry of pixel label
      logic       pix_wr;     // write merged box
      logic       clr_step;   // clear one valid row
      logic       q_start;    // latch truth box, reset best
      logic       q_rd;       // read entry at scan index
      logic       q_geom;     // compute overlap areas
      logic       q_mul;      // multiply areas
      logic       q_div_start;
      logic       q_div_step;
      logic       q_cmp;      // compare score with best
      logic       q_next;     // advance scan index
      logic       out_load;   // load result register
   } biou_cmd_type;

   typedef struct packed {
      logic scan_done;        // scan index reached limit
      logic clr_done;
      logic div_done;
      logic div_needed;       // set when candidate needs a divide
   } biou_stat_type;

endpackage

@@ hw/rtl/biou_ctrl.sv @@
module biou_ctrl
   import biou_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  logic [1:0]    req_op,
   input  logic          rsp_busy,
   output biou_cmd_type  cmd,
   input  biou_stat_type stat
);

   typedef enum logic [3:0] {
      S_IDLE, S_PIX_RD, S_PIX_WR, S_CLR, S_QRD, S_QGEOM, S_QMUL,
      S_QDIV0, S_QDIV, S_QCMP, S_QOUT
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               case (req_op)
                  OpPixel: begin
                     cmd.pix_rd = 1'b1;
                     state_in = S_PIX_WR;
                  end
                  OpClear: state_in = S_CLR;
                  OpQuery: begin
                     cmd.q_start = 1'b1;
                     state_in = S_QRD;
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_PIX_RD: state_in = S_PIX_WR;
         S_PIX_WR: begin
            cmd.pix_wr = 1'b1;
            state_in = S_IDLE;
         end
         S_CLR: begin
            cmd.clr_step = 1'b1;
            if (stat.clr_done) state_in = S_IDLE;
         end
         S_QRD: begin
            if (stat.scan_done) begin
               state_in = S_QOUT;
            end else begin
               cmd.q_rd = 1'b1;
               state_in = S_QGEOM;
            end
         end
         S_QGEOM: begin
            cmd.q_geom = 1'b1;
            state_in = S_QMUL;
         end
         S_QMUL: begin
            cmd.q_mul = 1'b1;
            state_in = S_QDIV0;
         end
         S_QDIV0: begin
            if (stat.div_needed) begin
               cmd.q_div_start = 1'b1;
               state_in = S_QDIV;
            end else begin
               state_in = S_QCMP;
            end
         end
         S_QDIV: begin
            cmd.q_div_step = 1'b1;
            if (stat.div_done) state_in = S_QCMP;
         end
         S_QCMP: begin
            cmd.q_cmp = 1'b1;
            cmd.q_next = 1'b1;
            state_in = S_QRD;
         end
         S_QOUT: begin
            if (!rsp_busy) begin
               cmd.out_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule

@@ hw/rtl/biou_dp.sv @@
module biou_dp
   import biou_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  biou_cmd_type         cmd,
   output biou_stat_type        stat,
   input  logic [CoordW-1:0]    req_row,
   input  logic [CoordW-1:0]    req_col,
   input  logic [LabelW-1:0]    req_label,
   input  logic                 csr_valid,
   input  logic [1:0]           csr_index,
   input  logic [31:0]          csr_data,
   output logic [IouW-1:0]      res_iou,
   output logic [LabelIdxW-1:0] res_label,
   output logic [3:0]           res_bucket,
   output logic                 res_sat
);

   // configuration
   logic [NumClW-1:0] num_cl_ff;
   logic [HwW-1:0]    hw_ff;
   logic [CorrW-1:0]  corr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_cl_ff <= '0;
         hw_ff     <= HwW'(14);
         corr_ff   <= CorrW'(85);
      end else if (csr_valid) begin
         case (csr_index)
            CsrNumClusters: num_cl_ff <= csr_data[NumClW-1:0];
            CsrHalfWidth:   hw_ff     <= csr_data[HwW-1:0];
            CsrAreaCorr:    corr_ff   <= csr_data[CorrW-1:0];
            default: ;
         endcase
      end
   end

   // box table memory; valid bits in a separate memory cleared by sweep
   logic [4*CoordW-1:0]  box_mem [NumLabels];
   logic                 vld_mem [NumLabels];
   logic [4*CoordW-1:0]  rd_box_ff;
   logic                 rd_vld_ff;

   logic                 pix_ok_ff;
   logic [LabelIdxW-1:0] pix_lab_ff;
   logic [CoordW-1:0]    pix_row_ff, pix_col_ff;
   logic [LabelIdxW:0]   clr_cnt_ff;
   logic [LabelIdxW:0]   scan_ff;

   logic [LabelIdxW-1:0] rd_addr;
   logic                 rd_en;
   assign rd_addr = cmd.pix_rd ? req_label[LabelIdxW-1:0] : scan_ff[LabelIdxW-1:0];
   assign rd_en   = cmd.pix_rd || cmd.q_rd;

   logic [CoordW-1:0] m_rmin, m_rmax, m_cmin, m_cmax;
   always_comb begin
      if (!rd_vld_ff) begin
         m_rmin = pix_row_ff;
         m_rmax = pix_row_ff;
         m_cmin = pix_col_ff;
         m_cmax = pix_col_ff;
      end else begin
         m_rmin = rd_box_ff[4*CoordW-1:3*CoordW];
         m_rmax = rd_box_ff[3*CoordW-1:2*CoordW];
         m_cmin = rd_box_ff[2*CoordW-1:CoordW];
         m_cmax = rd_box_ff[CoordW-1:0];
         if (pix_row_ff < m_rmin) m_rmin = pix_row_ff;
         if (pix_row_ff > m_rmax) m_rmax = pix_row_ff;
         if (pix_col_ff < m_cmin) m_cmin = pix_col_ff;
         if (pix_col_ff > m_cmax) m_cmax = pix_col_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_box_ff <= box_mem[rd_addr];
         rd_vld_ff <= vld_mem[rd_addr];
      end
      if (cmd.pix_wr && pix_ok_ff) begin
         box_mem[pix_lab_ff] <= {m_rmin, m_rmax, m_cmin, m_cmax};
      end
      if (cmd.clr_step) begin
         vld_mem[clr_cnt_ff[LabelIdxW-1:0]] <= 1'b0;
      end else if (cmd.pix_wr && pix_ok_ff) begin
         vld_mem[pix_lab_ff] <= 1'b1;
      end
      if (cmd.pix_rd) begin
         pix_ok_ff  <= !req_label[LabelW-1];
         pix_lab_ff <= req_label[LabelIdxW-1:0];
         pix_row_ff <= req_row;
         pix_col_ff <= req_col;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
      end else if (cmd.clr_step) begin
         clr_cnt_ff <= stat.clr_done ? '0 : clr_cnt_ff + 1'b1;
      end
   end
   assign stat.clr_done = (clr_cnt_ff == (LabelIdxW+1)'(NumLabels - 1));

   // query: truth box and scan
   logic signed [SCoordW-1:0] tr0_ff, tr1_ff, tc0_ff, tc1_ff;
   logic signed [AreaW:0]     area_t_ff;
   logic [NumClW-1:0]         limit;
   logic [HwW:0]              side;

   assign limit = (num_cl_ff > NumClW'(NumLabels)) ? NumClW'(NumLabels) : num_cl_ff;
   assign side  = {hw_ff, 1'b1};

   always_ff @(posedge clock) begin
      if (cmd.q_start) begin
         tr0_ff <= $signed({2'b0, req_row}) - $signed(SCoordW'(hw_ff));
         tr1_ff <= $signed({2'b0, req_row}) + $signed(SCoordW'(hw_ff));
         tc0_ff <= $signed({2'b0, req_col}) - $signed(SCoordW'(hw_ff));
         tc1_ff <= $signed({2'b0, req_col}) + $signed(SCoordW'(hw_ff));
         area_t_ff <= $signed((AreaW+1)'(side) * (AreaW+1)'(side))
                    - $signed((AreaW+1)'(corr_ff));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_ff <= '0;
      end else if (cmd.q_start) begin
         scan_ff <= '0;
      end else if (cmd.q_next) begin
         scan_ff <= scan_ff + 1'b1;
      end
   end
   assign stat.scan_done = ((NumClW)'(scan_ff) >= limit);

   // overlap geometry
   logic signed [SCoordW-1:0] pr0, pr1, pc0, pc1;
   logic signed [SCoordW-1:0] ir0, ir1, ic0, ic1;
   logic                      g_hit_ff;
   logic [CoordW:0]           ph_ff, pw_ff, ih_ff, iw_ff;

   assign pr0 = $signed({2'b0, rd_box_ff[4*CoordW-1:3*CoordW]});
   assign pr1 = $signed({2'b0, rd_box_ff[3*CoordW-1:2*CoordW]});
   assign pc0 = $signed({2'b0, rd_box_ff[2*CoordW-1:CoordW]});
   assign pc1 = $signed({2'b0, rd_box_ff[CoordW-1:0]});
   assign ir0 = (tr0_ff > pr0) ? tr0_ff : pr0;
   assign ir1 = (tr1_ff < pr1) ? tr1_ff : pr1;
   assign ic0 = (tc0_ff > pc0) ? tc0_ff : pc0;
   assign ic1 = (tc1_ff < pc1) ? tc1_ff : pc1;

   always_ff @(posedge clock) begin
      if (cmd.q_geom) begin
         g_hit_ff <= rd_vld_ff && !(tr0_ff > pr1 || pr0 > tr1_ff
                                  || tc0_ff > pc1 || pc0 > tc1_ff);
         ph_ff <= CoordW'(pr1 - pr0) + 1'b1;
         pw_ff <= CoordW'(pc1 - pc0) + 1'b1;
         ih_ff <= CoordW'(ir1 - ir0) + 1'b1;
         iw_ff <= CoordW'(ic1 - ic0) + 1'b1;
      end
   end

   logic [AreaW-1:0] area_p_ff, area_i_ff;
   logic             m_hit_ff;
   always_ff @(posedge clock) begin
      if (cmd.q_mul) begin
         area_p_ff <= AreaW'(ph_ff) * AreaW'(pw_ff);
         area_i_ff <= AreaW'(ih_ff) * AreaW'(iw_ff);
         m_hit_ff  <= g_hit_ff;
      end
   end

   logic signed [UnionW-1:0] uni;
   assign uni = $signed({2'b0, area_p_ff}) + $signed(UnionW'(area_t_ff))
              - $signed({2'b0, area_i_ff});
   assign stat.div_needed = m_hit_ff && (uni > 0);

   // restoring divider, one quotient bit per cycle
   logic [DivW-1:0]    quo_ff;
   logic [UnionW-1:0]  rem_ff;
   logic [UnionW-2:0]  den_ff;
   logic [DivCntW-1:0] dcnt_ff;
   logic [UnionW:0]    rem_sh;
   logic [UnionW:0]    rem_sub;

   assign rem_sh  = {rem_ff, quo_ff[DivW-1]};
   assign rem_sub = rem_sh - {2'b0, den_ff};
   assign stat.div_done = (dcnt_ff == DivCntW'(DivW - 1));

   always_ff @(posedge clock) begin
      if (cmd.q_div_start) begin
         quo_ff  <= {area_i_ff, IouFracBits'(0)};
         rem_ff  <= '0;
         den_ff  <= uni[UnionW-2:0];
         dcnt_ff <= '0;
      end else if (cmd.q_div_step) begin
         dcnt_ff <= dcnt_ff + 1'b1;
         if (!rem_sub[UnionW]) begin
            rem_ff <= rem_sub[UnionW-1:0];
            quo_ff <= {quo_ff[DivW-2:0], 1'b1};
         end else begin
            rem_ff <= rem_sh[UnionW-1:0];
            quo_ff <= {quo_ff[DivW-2:0], 1'b0};
         end
      end
   end

   // score and best tracking
   logic [IouW-1:0]      score;
   logic                 score_sat;
   logic                 div_path_ff;
   always_ff @(posedge clock) begin
      if (cmd.q_div_start) div_path_ff <= 1'b1;
      else if (cmd.q_mul) div_path_ff <= 1'b0;
   end

   always_comb begin
      score = '0;
      score_sat = 1'b0;
      if (m_hit_ff) begin
         if (uni == 0) begin
            score = IouMax;
            score_sat = 1'b1;
         end else if (div_path_ff) begin
            if (quo_ff > DivW'(IouMax)) begin
               score = IouMax;
               score_sat = 1'b1;
            end else begin
               score = quo_ff[IouW-1:0];
            end
         end
      end
   end

   logic [IouW-1:0]      best_ff;
   logic [LabelIdxW-1:0] best_k_ff;
   logic                 best_sat_ff;
   always_ff @(posedge clock) begin
      if (cmd.q_start) begin
         best_ff     <= '0;
         best_k_ff   <= '0;
         best_sat_ff <= 1'b0;
      end else if (cmd.q_cmp && score > best_ff) begin
         best_ff     <= score;
         best_k_ff   <= scan_ff[LabelIdxW-1:0];
         best_sat_ff <= score_sat;
      end
   end

   logic [IouW+3:0] b10;
   logic [3:0]      bucket;
   assign b10    = ({4'b0, best_ff} << 3) + ({4'b0, best_ff} << 1);
   assign bucket = (b10[IouW+3:IouFracBits] > 6'd9) ? 4'd9
                 : b10[IouFracBits+3:IouFracBits];

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         res_iou    <= best_ff;
         res_label  <= best_k_ff;
         res_bucket <= bucket;
         res_sat    <= best_sat_ff;
      end
   end

endmodule

@@ hw/rtl/box_iou_best_match_top.sv @@
// channel   direction   handshake              payload
// req_      in          req_valid / req_stall  op, row, col, label
// rsp_      out         rsp_valid / rsp_stall  best_iou, best_label, iou_bucket, saturated
// csr_      in          csr_valid / csr_ready  index, data
//
// a pixel request reads its label's table entry, then merges and writes the box back;
// a clear walks every table entry in turn, clearing its valid bit
// query: reads, overlaps and compares each label below num_clusters in turn, running
// the one-bit-per-cycle divider for each overlapping label; the table has a single port
// after reset a pass over the table clears the valid bits, no request taken meanwhile
// a query result waits in the output register while rsp_stall is high
module box_iou_best_match_top
   import biou_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [1:0]           req_op,
   input  logic [CoordW-1:0]    req_row,
   input  logic [CoordW-1:0]    req_col,
   input  logic signed [LabelW-1:0] req_label,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [IouW-1:0]      rsp_best_iou,
   output logic [LabelIdxW-1:0] rsp_best_label,
   output logic [3:0]           rsp_iou_bucket,
   output logic                 rsp_saturated,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [1:0]           csr_index,
   input  logic [31:0]          csr_data
);

   biou_cmd_type  cmd;
   biou_stat_type stat;
   logic          rsp_valid_ff;

   // config always accepted; the user must write it only while idle, the block does not enforce this
   assign csr_ready = 1'b1;

   biou_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_op    (req_op),
      .rsp_busy  (rsp_valid_ff && rsp_stall),
      .cmd       (cmd),
      .stat      (stat)
   );

   biou_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_row    (req_row),
      .req_col    (req_col),
      .req_label  (req_label),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .res_iou    (rsp_best_iou),
      .res_label  (rsp_best_label),
      .res_bucket (rsp_iou_bucket),
      .res_sat    (rsp_saturated)
   );

   // output register valid: set on load, cleared when taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end
   assign rsp_valid = rsp_valid_ff;

endmodule

@@ dv/biou_checker.sv @@
`timescale 1ns / 1ps

module biou_checker
   import biou_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_stall,
   input  logic [1:0]               req_op,
   input  logic [CoordW-1:0]        req_row,
   input  logic [CoordW-1:0]        req_col,
   input  logic signed [LabelW-1:0] req_label,
   input  logic                     rsp_valid,
   input  logic                     rsp_stall,
   input  logic [IouW-1:0]          rsp_best_iou,
   input  logic [LabelIdxW-1:0]     rsp_best_label,
   input  logic [3:0]               rsp_iou_bucket,
   input  logic                     rsp_saturated,
   input  logic                     csr_valid,
   input  logic                     csr_ready,
   input  logic [1:0]               csr_index,
   input  logic [31:0]              csr_data,
   output int                       errors,
   output int                       pending
);

   typedef struct packed {
      logic [IouW-1:0]      iou;
      logic [LabelIdxW-1:0] label;
      logic [3:0]           bucket;
      logic                 sat;
   } match_type;

   match_type match_q[$];

   logic [NumClW-1:0] num_clusters;
   logic [HwW-1:0]    half_width;
   logic [CorrW-1:0]  area_corr;

   bit                box_ok   [NumLabels];
   logic [CoordW-1:0] box_rmin [NumLabels];
   logic [CoordW-1:0] box_rmax [NumLabels];
   logic [CoordW-1:0] box_cmin [NumLabels];
   logic [CoordW-1:0] box_cmax [NumLabels];

   function automatic longint lmin(longint a, longint b);
      return (a < b) ? a : b;
   endfunction

   function automatic longint lmax(longint a, longint b);
      return (a > b) ? a : b;
   endfunction

   // best iou of a truth box centered at (r, c) over the labels in range
   function automatic match_type best_match(logic [CoordW-1:0] r, logic [CoordW-1:0] c);
      longint hw, side, area_t, tr0, tr1, tc0, tc1, lim;
      longint pr0, pr1, pc0, pc1, area_p, area_i, uni, q, best, best_k, bkt;
      bit     best_sat, s;
      match_type m;
      hw = half_width;
      side = 2 * hw + 1;
      area_t = side * side - longint'(area_corr);
      tr0 = longint'(r) - hw;
      tr1 = longint'(r) + hw;
      tc0 = longint'(c) - hw;
      tc1 = longint'(c) + hw;
      lim = (num_clusters < NumLabels) ? num_clusters : NumLabels;
      best = 0;
      best_k = 0;
      best_sat = 0;
      for (int k = 0; k < lim; k++) begin
         if (!box_ok[k]) continue;
         pr0 = box_rmin[k];
         pr1 = box_rmax[k];
         pc0 = box_cmin[k];
         pc1 = box_cmax[k];
         if (tr0 > pr1 || pr0 > tr1 || tc0 > pc1 || pc0 > tc1) continue;
         area_p = (pr1 - pr0 + 1) * (pc1 - pc0 + 1);
         area_i = (lmin(tr1, pr1) - lmax(tr0, pr0) + 1) *
                  (lmin(tc1, pc1) - lmax(tc0, pc0) + 1);
         uni = area_p + area_t - area_i;
         s = 0;
         if (uni < 0) continue;
         if (uni == 0) begin
            q = IouMax;
            s = 1;
         end else begin
            q = (area_i << IouFracBits) / uni;
            if (q > IouMax) begin
               q = IouMax;
               s = 1;
            end
         end
         if (q > best) begin
            best = q;
            best_k = k;
            best_sat = s;
         end
      end
      bkt = (best * 10) >> IouFracBits;
      if (bkt > 9) bkt = 9;
      m.iou = best[IouW-1:0];
      m.label = best_k[LabelIdxW-1:0];
      m.bucket = bkt[3:0];
      m.sat = best_sat;
      return m;
   endfunction

   assign pending = match_q.size();

   always @(posedge clock) begin
      match_type m, got;
      int        lab;
      if (reset) begin
         num_clusters = '0;
         half_width = 8'd14;
         area_corr = 16'd85;
         foreach (box_ok[i]) box_ok[i] = 0;
         match_q.delete();
         errors = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CsrNumClusters: num_clusters = csr_data[NumClW-1:0];
               CsrHalfWidth:   half_width = csr_data[HwW-1:0];
               CsrAreaCorr:    area_corr = csr_data[CorrW-1:0];
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_best_iou, rsp_best_label, rsp_iou_bucket, rsp_saturated};
            if (match_q.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("ERROR: unexpected result iou=%h label=%0d bucket=%0d sat=%0b",
                           got.iou, got.label, got.bucket, got.sat);
            end else begin
               m = match_q.pop_front();
               if (got !== m) begin
                  errors++;
                  if (errors <= 10)
                     $display("ERROR: expected iou=%h label=%0d bucket=%0d sat=%0b,",
                              m.iou, m.label, m.bucket, m.sat,
                              " got iou=%h label=%0d bucket=%0d sat=%0b",
                              got.iou, got.label, got.bucket, got.sat);
               end
            end
         end
         if (req_valid && !req_stall) begin
            case (req_op)
               OpPixel: begin
                  lab = req_label;
                  if (lab >= 0 && lab < NumLabels) begin
                     if (!box_ok[lab]) begin
                        box_ok[lab] = 1;
                        box_rmin[lab] = req_row;
                        box_rmax[lab] = req_row;
                        box_cmin[lab] = req_col;
                        box_cmax[lab] = req_col;
                     end else begin
                        if (req_row < box_rmin[lab]) box_rmin[lab] = req_row;
                        if (req_row > box_rmax[lab]) box_rmax[lab] = req_row;
                        if (req_col < box_cmin[lab]) box_cmin[lab] = req_col;
                        if (req_col > box_cmax[lab]) box_cmax[lab] = req_col;
                     end
                  end
               end
               OpClear: foreach (box_ok[i]) box_ok[i] = 0;
               OpQuery: match_q.insert(match_q.size(), best_match(req_row, req_col));
               default: ;
            endcase
         end
      end
   end

   final begin
      if (match_q.size() != 0)
         $display("ERROR: %0d results never arrived", match_q.size());
   end

endmodule

@@ dv/box_iou_best_match_top_tb.sv @@
`timescale 1ns / 1ps

module box_iou_best_match_top_tb;
   import biou_pkg::*;

   // op code the block must ignore
   localparam logic [1:0] OpUnused = 2'd3;
   // idle wait long enough for a clear walking the whole table to finish
   localparam int IdleCycles = 4300;

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_stall;
   logic [1:0]               req_op;
   logic [CoordW-1:0]        req_row;
   logic [CoordW-1:0]        req_col;
   logic signed [LabelW-1:0] req_label;
   logic                     rsp_valid;
   logic                     rsp_stall;
   logic [IouW-1:0]          rsp_best_iou;
   logic [LabelIdxW-1:0]     rsp_best_label;
   logic [3:0]               rsp_iou_bucket;
   logic                     rsp_saturated;
   logic                     csr_valid;
   logic                     csr_ready;
   logic [1:0]               csr_index;
   logic [31:0]              csr_data;
   int                       errors;
   int                       pending;

   // sender burst state
   int burst_left = 0;
   // request for one long receiver hold-off
   bit long_hold_go = 0;

   // per-phase cluster centers, pixels land near them so queries overlap
   int center_r [32];
   int center_c [32];
   int cur_nc;

   box_iou_best_match_top dut (.*);

   biou_checker u_checker (.*);

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // generous limit, well above the slowest legal run
   initial begin
      #40ms;
      $display("Simulation FAILED");
      $finish;
   end

   // receiver: stretches of no, light and heavy stall, plus one long hold-off
   initial begin
      int mode, stretch;
      rsp_stall = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (long_hold_go) begin
            // hold off long enough that queries back up into req_stall
            rsp_stall = 1'b1;
            repeat (3000) @(negedge clock);
            long_hold_go = 0;
         end
         mode = $urandom_range(0, 2);
         stretch = $urandom_range(20, 200);
         repeat (stretch) begin
            case (mode)
               0: rsp_stall = 1'b0;
               1: rsp_stall = ($urandom_range(0, 2) == 0);
               default: rsp_stall = ($urandom_range(0, 3) != 0);
            endcase
            @(negedge clock);
         end
      end
   end

   // one register write, waits for csr_ready
   task automatic write_reg(logic [1:0] idx, logic [31:0] value);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data = value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // drain all results, then let a trailing clear finish
   task automatic wait_idle();
      req_valid = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (IdleCycles) @(negedge clock);
   endtask

   task automatic set_config(int nc, int hw, int corr, bit junk);
      wait_idle();
      // junk above each field's width must be dropped by the block
      write_reg(CsrNumClusters, junk ? (nc | ($urandom << NumClW)) : nc);
      write_reg(CsrHalfWidth, junk ? (hw | ($urandom << HwW)) : hw);
      write_reg(CsrAreaCorr, junk ? (corr | ($urandom << CorrW)) : corr);
      cur_nc = nc;
   endtask

   // offer one request, bursts separated by random gaps
   task automatic send(logic [1:0] op, int row, int col, int lab);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid = 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      req_valid = 1'b1;
      req_op = op;
      req_row = CoordW'(row);
      req_col = CoordW'(col);
      req_label = LabelW'(lab);
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      burst_left--;
   endtask

   // random phase: mostly pixels around the centers, some queries and noise
   task automatic random_phase(int count);
      int lab, pick;
      for (int i = 0; i < 32; i++) begin
         center_r[i] = $urandom_range(0, 300);
         center_c[i] = $urandom_range(0, 300);
      end
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(0, 99);
         lab = $urandom_range(0, cur_nc + 3);
         if (pick < 76)
            send(OpPixel, center_r[lab % 32] + $urandom_range(0, 15),
                 center_c[lab % 32] + $urandom_range(0, 15), lab);
         else if (pick < 88)
            send(OpQuery, center_r[lab % 32] + $urandom_range(0, 20),
                 center_c[lab % 32] + $urandom_range(0, 20), 0);
         else if (pick < 89)
            send(OpClear, $urandom, $urandom, $urandom);
         else if (pick < 93)
            send(OpPixel, $urandom, $urandom, -$urandom_range(1, 4096));
         else if (pick < 95)
            send(OpUnused, $urandom, $urandom, $urandom);
         else
            // anything at all in every field
            send(2'($urandom_range(0, 3)), $urandom, $urandom, $urandom);
      end
   endtask

   initial begin
      int nc, hw, corr;
      reset = 1'b1;
      req_valid = 1'b0;
      req_op = OpPixel;
      req_row = '0;
      req_col = '0;
      req_label = '0;
      csr_valid = 1'b0;
      csr_index = CsrNumClusters;
      csr_data = '0;
      cur_nc = 0;
      repeat (12) @(negedge clock);
      reset = 1'b0;

      // reset config compares no labels at all
      send(OpPixel, 5, 5, 0);
      send(OpQuery, 5, 5, 0);
      send(OpUnused, 4095, 4095, -1);

      // one-pixel truth box over one-pixel label: union of zero saturates
      set_config(16, 0, 1, 0);
      send(OpQuery, 5, 5, 0);
      send(OpQuery, 2000, 2000, 0);

      // 3x3 boxes with a big correction saturate, tie goes to the lower label
      set_config(16, 1, 8, 0);
      send(OpPixel, 100, 100, 1);
      send(OpPixel, 102, 102, 1);
      send(OpPixel, 100, 100, 2);
      send(OpPixel, 102, 102, 2);
      send(OpQuery, 101, 101, 0);

      // exact match without correction gives one, the top bucket
      set_config(16, 1, 0, 0);
      send(OpQuery, 101, 101, 0);
      send(OpQuery, 103, 103, 0);

      // largest correction at the widest half-width still leaves the truth area positive
      set_config(16, 255, 65535, 0);
      send(OpQuery, 101, 101, 0);

      // extreme coordinates and labels, background and out-of-range labels
      set_config(8191, 14, 85, 0);
      send(OpPixel, 4095, 4095, 4095);
      send(OpPixel, 4090, 0, 4095);
      send(OpPixel, 0, 4095, -1);
      send(OpPixel, 0, 0, -4096);
      send(OpQuery, 4095, 4095, 0);
      set_config(4096, 255, 0, 0);
      send(OpQuery, 0, 0, 0);
      send(OpClear, 0, 0, 0);
      send(OpQuery, 101, 101, 0);

      // random phases, one setting each, with random clears inside the phases
      for (int p = 0; p < 10; p++) begin
         nc = $urandom_range(1, 24);
         hw = ($urandom_range(0, 4) == 0) ? 255 : $urandom_range(0, 40);
         corr = ($urandom_range(0, 4) == 0) ? 65535 : $urandom_range(0, 200);
         if (p == 0) begin
            hw = 0;
            corr = 0;
         end
         set_config(nc, hw, corr, p[0]);
         if (p == 2) long_hold_go = 1;
         random_phase(170);
      end

      wait_idle();
      if (errors == 0 && pending == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

@@ box_iou_best_match_top.f @@
hw/rtl/biou_pkg.sv
hw/rtl/biou_ctrl.sv
hw/rtl/biou_dp.sv
hw/rtl/box_iou_best_match_top.sv
dv/biou_checker.sv
dv/box_iou_best_match_top_tb.sv
